// ----- rtl/core/acc_pkg.sv -----
// Shared types and constants for the alarm clock controller.
package acc_pkg;

    // Button positions inside the sampled button word.
    localparam int BTN_SET_TIME    = 0;
    localparam int BTN_SET_ALARM   = 1;
    localparam int BTN_INC_HOURS   = 2;
    localparam int BTN_INC_MINUTES = 3;
    localparam int BTN_SNOOZE      = 4;
    localparam int NUM_BUTTONS     = 5;

    // Operating mode, one-hot.
    typedef enum logic [2:0] {
        MODE_RUN       = 3'b001,
        MODE_SET_TIME  = 3'b010,
        MODE_SET_ALARM = 3'b100
    } mode_t;

    // Mode codes as reported on the result stream.
    localparam logic [1:0] MODE_CODE_RUN       = 2'd0;
    localparam logic [1:0] MODE_CODE_SET_TIME  = 2'd1;
    localparam logic [1:0] MODE_CODE_SET_ALARM = 2'd2;

    // Blinds motor pulse codes.
    localparam logic [1:0] MOVE_NONE  = 2'd0;
    localparam logic [1:0] MOVE_OPEN  = 2'd1;
    localparam logic [1:0] MOVE_CLOSE = 2'd2;

    // Reset value of the blinds hold register.
    localparam logic [4:0] HOLD_HOURS_RESET = 5'd12;

    // Clock, alarm and blinds state carried from poll to poll.
    typedef struct packed {
        mode_t      mode;
        logic [5:0] clock_seconds;
        logic [5:0] clock_minutes;
        logic [4:0] clock_hours;
        logic [4:0] alarm_hours;
        logic [5:0] alarm_minutes;
        logic       alarm_armed;
        logic       bell_flag;
        logic       sound;
        logic       blinds_open;
        logic [4:0] close_hour;
        logic [NUM_BUTTONS-1:0] prev_buttons;
    } clk_state_t;

    localparam clk_state_t STATE_RESET = '{
        mode:          MODE_RUN,
        clock_seconds: 6'd0,
        clock_minutes: 6'd0,
        clock_hours:   5'd0,
        alarm_hours:   5'd0,
        alarm_minutes: 6'd0,
        alarm_armed:   1'b0,
        bell_flag:     1'b0,
        sound:         1'b0,
        blinds_open:   1'b0,
        close_hour:    5'd0,
        prev_buttons:  '0
    };

    // One result beat; the first member sits in the highest bits.
    typedef struct packed {
        logic       blinds_state;
        logic [1:0] blinds_move;
        logic       sound_on;
        logic [5:0] shown_seconds;
        logic [5:0] shown_minutes;
        logic [4:0] shown_hours;
        logic [1:0] mode_now;
    } result_t;

endpackage

// ----- rtl/core/acc_step.sv -----
// Next-state and result logic for one button poll of the alarm clock.
module acc_step #(
    parameter int TICKS_PER_SECOND = 10,
    localparam int TW = (TICKS_PER_SECOND > 1) ? $clog2(TICKS_PER_SECOND) : 1
) (
    input  logic [acc_pkg::NUM_BUTTONS-1:0] buttons,
    input  logic [4:0]                      hold_hours,
    input  acc_pkg::clk_state_t             state_cur,
    input  logic [TW-1:0]                   tenths_cur,
    output acc_pkg::clk_state_t             state_next,
    output logic [TW-1:0]                   tenths_next,
    output acc_pkg::result_t                result
);

    logic [acc_pkg::NUM_BUTTONS-1:0] press;
    logic [TW:0] tenths_inc;
    logic        tick_roll;
    logic [6:0]  sec_plus2;
    logic        carry2;
    logic        min_wraps;
    logic [4:0]  hour_inc;
    logic [4:0]  hours_after2;
    logic [5:0]  close_sum;
    logic [4:0]  close_calc;
    logic        alarm_match;

    // Press is a falling edge against the previous sample.
    assign press = state_cur.prev_buttons & ~buttons;

    // Tick counter and the one-second rollover it causes.
    assign tenths_inc = {1'b0, tenths_cur} + (TW+1)'(1);
    assign tick_roll  = (tenths_inc >= (TW+1)'(TICKS_PER_SECOND));

    // Clock carries used by the two added seconds and the close hour.
    assign sec_plus2    = {1'b0, state_cur.clock_seconds} + 7'd2;
    assign carry2       = (sec_plus2 >= 7'd60);
    assign min_wraps    = ({1'b0, state_cur.clock_minutes} + 7'd1 >= 7'd60);
    assign hour_inc     = ({1'b0, state_cur.clock_hours} + 6'd1 >= 6'd24) ? 5'd0
                        : state_cur.clock_hours + 5'd1;
    assign hours_after2 = (carry2 && min_wraps) ? hour_inc : state_cur.clock_hours;

    // Close hour is the hour after the added seconds plus the hold, modulo 24.
    assign close_sum  = {1'b0, hours_after2} + {1'b0, hold_hours};
    always_comb
    begin
        if (close_sum >= 6'd48)
        begin
            close_calc = 5'(close_sum - 6'd48);
        end
        else if (close_sum >= 6'd24)
        begin
            close_calc = 5'(close_sum - 6'd24);
        end
        else
        begin
            close_calc = close_sum[4:0];
        end
    end

    assign alarm_match = state_cur.alarm_armed
                      && (state_cur.alarm_hours == state_cur.clock_hours)
                      && (state_cur.alarm_minutes == state_cur.clock_minutes)
                      && (state_cur.clock_seconds == 6'd0);

    // Mode handling, bell and blinds priority chain, and clock advance.
    always_comb
    begin
        logic       add2;
        logic [1:0] move;
        logic [6:0] sec_sum;

        state_next  = state_cur;
        tenths_next = tenths_cur;
        add2        = 1'b0;
        move        = acc_pkg::MOVE_NONE;
        sec_sum     = '0;

        case (state_cur.mode)
            acc_pkg::MODE_SET_TIME:
            begin
                if (press[acc_pkg::BTN_SET_TIME])
                begin
                    state_next.mode = acc_pkg::MODE_RUN;
                end
                if (press[acc_pkg::BTN_INC_HOURS])
                begin
                    state_next.clock_hours = (state_cur.clock_hours >= 5'd23) ? 5'd0
                                           : state_cur.clock_hours + 5'd1;
                end
                if (press[acc_pkg::BTN_INC_MINUTES])
                begin
                    state_next.clock_minutes = (state_cur.clock_minutes >= 6'd59) ? 6'd0
                                             : state_cur.clock_minutes + 6'd1;
                end
            end
            acc_pkg::MODE_SET_ALARM:
            begin
                if (press[acc_pkg::BTN_SET_ALARM])
                begin
                    state_next.mode = acc_pkg::MODE_RUN;
                end
                if (press[acc_pkg::BTN_INC_HOURS])
                begin
                    state_next.alarm_hours = (state_cur.alarm_hours >= 5'd23) ? 5'd0
                                           : state_cur.alarm_hours + 5'd1;
                end
                if (press[acc_pkg::BTN_INC_MINUTES])
                begin
                    state_next.alarm_minutes = (state_cur.alarm_minutes >= 6'd59) ? 6'd0
                                             : state_cur.alarm_minutes + 6'd1;
                end
                state_next.alarm_armed = 1'b1;
            end
            default:
            begin
                // Run mode: mode buttons first.
                state_next.mode = acc_pkg::MODE_RUN;
                if (press[acc_pkg::BTN_SET_TIME])
                begin
                    state_next.mode = acc_pkg::MODE_SET_TIME;
                end
                else if (press[acc_pkg::BTN_SET_ALARM])
                begin
                    state_next.mode = acc_pkg::MODE_SET_ALARM;
                end

                // Bell, snooze and blinds in priority order.
                if (alarm_match)
                begin
                    state_next.bell_flag = 1'b1;
                end
                else if (press[acc_pkg::BTN_SNOOZE])
                begin
                    state_next.bell_flag = 1'b0;
                    state_next.sound     = 1'b0;
                end
                else if (state_cur.bell_flag)
                begin
                    state_next.sound = 1'b1;
                    if (!state_cur.blinds_open)
                    begin
                        move                   = acc_pkg::MOVE_OPEN;
                        add2                   = 1'b1;
                        state_next.blinds_open = 1'b1;
                        state_next.close_hour  = close_calc;
                    end
                end
                else if (state_cur.blinds_open
                         && (state_cur.close_hour == state_cur.clock_hours))
                begin
                    move                   = acc_pkg::MOVE_CLOSE;
                    add2                   = 1'b1;
                    state_next.blinds_open = 1'b0;
                end
                else
                begin
                    state_next.sound = 1'b0;
                end

                // Tick, then the added seconds and the tick share one carry.
                tenths_next = tick_roll ? '0 : tenths_inc[TW-1:0];
                sec_sum = {1'b0, state_cur.clock_seconds}
                        + (add2 ? 7'd2 : 7'd0) + (tick_roll ? 7'd1 : 7'd0);
                if (sec_sum >= 7'd60)
                begin
                    state_next.clock_seconds = 6'(sec_sum - 7'd60);
                    if (min_wraps)
                    begin
                        state_next.clock_minutes = 6'd0;
                        state_next.clock_hours   = hour_inc;
                    end
                    else
                    begin
                        state_next.clock_minutes = state_cur.clock_minutes + 6'd1;
                    end
                end
                else
                begin
                    state_next.clock_seconds = sec_sum[5:0];
                end
            end
        endcase

        state_next.prev_buttons = buttons;

        // Result beat from the updated state.
        result.blinds_state = state_next.blinds_open;
        result.blinds_move  = move;
        result.sound_on     = state_next.sound;
        case (state_next.mode)
            acc_pkg::MODE_SET_ALARM:
            begin
                result.mode_now      = acc_pkg::MODE_CODE_SET_ALARM;
                result.shown_hours   = state_next.alarm_hours;
                result.shown_minutes = state_next.alarm_minutes;
                result.shown_seconds = 6'd0;
            end
            acc_pkg::MODE_SET_TIME:
            begin
                result.mode_now      = acc_pkg::MODE_CODE_SET_TIME;
                result.shown_hours   = state_next.clock_hours;
                result.shown_minutes = state_next.clock_minutes;
                result.shown_seconds = state_next.clock_seconds;
            end
            default:
            begin
                result.mode_now      = acc_pkg::MODE_CODE_RUN;
                result.shown_hours   = state_next.clock_hours;
                result.shown_minutes = state_next.clock_minutes;
                result.shown_seconds = state_next.clock_seconds;
            end
        endcase
    end

endmodule

// ----- rtl/core/alarm_clock_controller_core.sv -----
// Alarm clock controller: input register, poll logic, state and result register.
// m_axis_tvalid rises once the accepted input beat has passed the input register and then the result register.
// Throughput: one poll per cycle while the result is taken, set by the single pass from input to result register.
// While a result waits, the input register takes one more beat and then stalls the input.
// Reset (rst_n low, asynchronous) empties both registers, sets run mode, zeroes
// clock, alarm and blinds state, and loads the blinds hold register with 12.
module alarm_clock_controller_core #(
    parameter int TICKS_PER_SECOND = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata,     // blinds_hold_hours
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [0] set_time_btn, [1] set_alarm_btn, [2] inc_hours_btn,
    // [3] inc_minutes_btn, [4] snooze_btn, [7:5] zero
    input  logic [7:0]  s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [1:0] mode_now, [6:2] shown_hours, [12:7] shown_minutes,
    // [18:13] shown_seconds, [19] sound_on, [21:20] blinds_move,
    // [22] blinds_state, [23] zero
    output logic [23:0] m_axis_tdata
);

    localparam int TW = (TICKS_PER_SECOND > 1) ? $clog2(TICKS_PER_SECOND) : 1;

    logic                            in_valid_reg;
    logic [acc_pkg::NUM_BUTTONS-1:0] in_buttons_reg;
    logic                            out_valid_reg;
    acc_pkg::result_t                out_data_reg;
    logic [4:0]                      hold_hours_reg;
    acc_pkg::clk_state_t             state_reg;
    acc_pkg::clk_state_t             state_next;
    logic [TW-1:0]                   tenths_reg;
    logic [TW-1:0]                   tenths_next;
    acc_pkg::result_t                result;
    logic                            advance;

    // The held poll moves on when the result register is free or being emptied.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_data_reg};

    // Blinds hold configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_hours_reg <= acc_pkg::HOLD_HOURS_RESET;
        end
        else if (cfg_we)
        begin
            hold_hours_reg <= cfg_wdata;
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_buttons_reg <= s_axis_tdata[acc_pkg::NUM_BUTTONS-1:0];
        end
    end

    // Poll logic between the input and result registers.
    acc_step #(
        .TICKS_PER_SECOND(TICKS_PER_SECOND)
    ) u_step (
        .buttons     (in_buttons_reg),
        .hold_hours  (hold_hours_reg),
        .state_cur   (state_reg),
        .tenths_cur  (tenths_reg),
        .state_next  (state_next),
        .tenths_next (tenths_next),
        .result      (result)
    );

    // Clock state, updated once per poll that reaches the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= acc_pkg::STATE_RESET;
            tenths_reg <= '0;
        end
        else if (advance)
        begin
            state_reg  <= state_next;
            tenths_reg <= tenths_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

endmodule
